// ===== rtl/cc_cv_charge_controller_unit_macros.svh =====
// Assertion macros used by the charge controller sequencer.
`ifndef CC_CV_CHARGE_CONTROLLER_UNIT_MACROS_SVH
`define CC_CV_CHARGE_CONTROLLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ccc_pkg.sv =====
// Package: types and constants of the CC/CV charge controller.
`default_nettype none
package ccc_pkg;

	// register and field widths
	localparam int MINV_W   = 18;
	localparam int SPAN_W   = 17;
	localparam int MA_W     = 16;
	localparam int MV_W     = 18;
	localparam int MS_W     = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int POT_W    = 8;
	localparam int KICK_W   = 4;
	localparam int STEP_W   = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLTAGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_SPAN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATED_CUR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VOLT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_CUR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_CUR   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd7;

	// register reset values
	localparam logic [MINV_W-1:0] RST_MIN_VOLTAGE  = 18'd64100;
	localparam logic [SPAN_W-1:0] RST_VOLTAGE_SPAN = 17'd24800;
	localparam logic [MA_W-1:0]   RST_RATED_CUR    = 16'd26400;
	localparam logic [MV_W-1:0]   RST_TARGET_VOLT  = 18'd70000;
	localparam logic [MA_W-1:0]   RST_CHARGE_CUR   = 16'd1000;
	localparam logic [MA_W-1:0]   RST_CUTOFF_CUR   = 16'd200;
	localparam logic              RST_TEST_MODE    = 1'b1;
	localparam logic [MS_W-1:0]   RST_IDLE_TIMEOUT = 32'd1800000;

	// fixed thresholds
	localparam logic [MV_W:0]     VOLT_MAX     = 19'd200000;
	localparam logic [MS_W-1:0]   EARLY_MS     = 32'd1100;
	localparam logic [MV_W:0]     OVERSHOOT_MV = 19'd1000;
	localparam logic [MA_W-1:0]   BAND_LOW_MA  = 16'd1000;
	localparam logic [MA_W-1:0]   BAND_HIGH_MA = 16'd5000;
	localparam logic [KICK_W-1:0] KICK_LIMIT   = 4'd10;
	localparam logic [STEP_W-1:0] DIV_STEPS    = 4'd8;

	typedef enum logic [2:0] {
		PH_SOFT  = 3'd0,
		PH_CC    = 3'd1,
		PH_CV    = 3'd2,
		PH_IDLE  = 3'd3,
		PH_DARK  = 3'd4,
		PH_FAULT = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		LED_OFF    = 2'd0,
		LED_RED    = 2'd1,
		LED_YELLOW = 2'd2,
		LED_GREEN  = 2'd3
	} led_t;

	typedef enum logic {
		SEQ_IDLE = 1'b0,
		SEQ_CALC = 1'b1
	} seq_state_t;

	// sequencer commands to the datapath and divider
	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	// status back to the sequencer
	typedef struct packed {
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/ccc_div.sv =====
// Restoring divider for the current pot code, one quotient bit per cycle.
`default_nettype none
module ccc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ccc_pkg::MA_W-1:0]      dividend,
	input  wire logic [ccc_pkg::MA_W-1:0]      divisor,
	output logic                               done,
	output logic [ccc_pkg::POT_W-1:0]          quotient
);

	logic [ccc_pkg::MA_W-1:0]   rem_q;
	logic [ccc_pkg::POT_W-1:0]  quo_q;
	logic                       sat_q;
	logic [ccc_pkg::STEP_W-1:0] cnt_q;
	logic                       done_q;
	logic [ccc_pkg::MA_W:0]     rem_sh;
	logic                       fits;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh = {rem_q, 1'b0};
		fits   = (rem_sh >= {1'b0, divisor});
	end

	// control: step count and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= ccc_pkg::DIV_STEPS;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ccc_pkg::STEP_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient; quotient >= 256 exactly when dividend >= divisor
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= (dividend >= divisor);
			rem_q <= dividend;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= ccc_pkg::MA_W'(rem_sh - {1'b0, divisor});
			end else begin
				rem_q <= rem_sh[ccc_pkg::MA_W-1:0];
			end
			quo_q <= {quo_q[ccc_pkg::POT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = sat_q ? '1 : quo_q;

endmodule
`default_nettype wire

// ===== rtl/ccc_ctrl.sv =====
// Sequencer: accepts one sample item, waits for the datapath, commits the result.
`default_nettype none
`include "cc_cv_charge_controller_unit_macros.svh"
module ccc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ccc_pkg::sts_t sts,
	output ccc_pkg::cmd_t      cmd
);

	ccc_pkg::seq_state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ccc_pkg::SEQ_IDLE: begin
				if (in_valid) begin
					state_d = ccc_pkg::SEQ_CALC;
				end
			end
			ccc_pkg::SEQ_CALC: begin
				if (sts.div_done && !sts.out_busy) begin
					state_d = ccc_pkg::SEQ_IDLE;
				end
			end
			default: state_d = ccc_pkg::SEQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ccc_pkg::SEQ_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ccc_pkg::SEQ_CALC: begin
				cmd.commit = sts.div_done && !sts.out_busy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccc_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CCC_ASSERT_NOW(a_commit_after_div, cmd.commit, sts.div_done, "commit before pot divide done")
	`CCC_ASSERT_NOW(a_commit_out_free, cmd.commit, !sts.out_busy, "commit over a waiting result")
	`CCC_ASSERT_NEXT(a_load_blocks_input, cmd.load, !in_ready, "input still open after load")
	`CCC_ASSERT_NEXT(a_load_clears_done, cmd.load, !sts.div_done, "divider done right after start")

endmodule
`default_nettype wire

// ===== rtl/ccc_datapath.sv =====
// Datapath: config registers, scaling pipeline, charge sequence state, result register.
`default_nettype none
module ccc_datapath #(
	parameter int CODE_BITS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [ccc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ccc_pkg::CFG_W-1:0]        cfg_data,
	// sample payload
	input  wire logic [CODE_BITS-1:0]             voltage_code,
	input  wire logic [CODE_BITS-1:0]             current_code,
	input  wire logic [ccc_pkg::MS_W-1:0]         now_ms,
	// sequencer
	input  wire ccc_pkg::cmd_t                    cmd,
	output logic                                  out_busy,
	// divider
	output logic [ccc_pkg::MA_W-1:0]              div_dividend,
	output logic [ccc_pkg::MA_W-1:0]              div_divisor,
	input  wire logic [ccc_pkg::POT_W-1:0]        div_quotient,
	// result
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [ccc_pkg::MV_W-1:0]              voltage_mv,
	output logic [ccc_pkg::MA_W-1:0]              current_ma,
	output logic [2:0]                            charge_state,
	output logic [1:0]                            led_color,
	output logic                                  output_enable,
	output logic                                  fans_on,
	output logic                                  display_on,
	output logic                                  watchdog_kick,
	output logic                                  pot_write,
	output logic [ccc_pkg::POT_W-1:0]             pot_code
);

	localparam int VP_W = CODE_BITS + ccc_pkg::SPAN_W;
	localparam int IP_W = CODE_BITS + ccc_pkg::MA_W;

	// configuration registers
	logic [ccc_pkg::MINV_W-1:0] min_volt_q;
	logic [ccc_pkg::SPAN_W-1:0] span_q;
	logic [ccc_pkg::MA_W-1:0]   rated_q;
	logic [ccc_pkg::MV_W-1:0]   target_q;
	logic [ccc_pkg::MA_W-1:0]   charge_q;
	logic [ccc_pkg::MA_W-1:0]   cutoff_q;
	logic                       test_mode_q;
	logic [ccc_pkg::MS_W-1:0]   timeout_q;

	// latched sample and scaling pipeline
	logic [CODE_BITS-1:0]       vcode_q, icode_q;
	logic [ccc_pkg::MS_W-1:0]   now_q;
	logic [VP_W-1:0]            vprod_s1;
	logic [IP_W-1:0]            iprod_s1;
	logic [ccc_pkg::MV_W:0]     volt_sum;
	logic [ccc_pkg::MV_W-1:0]   volt_s2;
	logic [ccc_pkg::MA_W-1:0]   cur_s2;

	// charge sequence state
	ccc_pkg::phase_t            phase_q, phase_d;
	ccc_pkg::led_t              led_q, led_d;
	logic [ccc_pkg::MS_W-1:0]   idle_start_q, idle_start_d;
	logic [ccc_pkg::KICK_W-1:0] kick_cnt_q, kick_cnt_d;
	logic                       out_on_q, out_on_d;
	logic                       fans_q, fans_d;
	logic                       disp_q, disp_d;
	logic                       kick_d, potw_d;
	logic [ccc_pkg::MS_W:0]     idle_end;
	logic [ccc_pkg::MV_W:0]     volt_limit;

	// result register
	logic                       out_valid_q;
	logic [ccc_pkg::MV_W-1:0]   voltage_mv_q;
	logic [ccc_pkg::MA_W-1:0]   current_ma_q;
	logic [2:0]                 charge_state_q;
	logic [1:0]                 led_color_q;
	logic                       output_enable_q, fans_on_q, display_on_q;
	logic                       watchdog_kick_q, pot_write_q;
	logic [ccc_pkg::POT_W-1:0]  pot_code_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_volt_q  <= ccc_pkg::RST_MIN_VOLTAGE;
			span_q      <= ccc_pkg::RST_VOLTAGE_SPAN;
			rated_q     <= ccc_pkg::RST_RATED_CUR;
			target_q    <= ccc_pkg::RST_TARGET_VOLT;
			charge_q    <= ccc_pkg::RST_CHARGE_CUR;
			cutoff_q    <= ccc_pkg::RST_CUTOFF_CUR;
			test_mode_q <= ccc_pkg::RST_TEST_MODE;
			timeout_q   <= ccc_pkg::RST_IDLE_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				ccc_pkg::CFG_MIN_VOLTAGE:  min_volt_q  <= cfg_data[ccc_pkg::MINV_W-1:0];
				ccc_pkg::CFG_VOLTAGE_SPAN: span_q      <= cfg_data[ccc_pkg::SPAN_W-1:0];
				ccc_pkg::CFG_RATED_CUR:    rated_q     <= cfg_data[ccc_pkg::MA_W-1:0];
				ccc_pkg::CFG_TARGET_VOLT:  target_q    <= cfg_data[ccc_pkg::MV_W-1:0];
				ccc_pkg::CFG_CHARGE_CUR:   charge_q    <= cfg_data[ccc_pkg::MA_W-1:0];
				ccc_pkg::CFG_CUTOFF_CUR:   cutoff_q    <= cfg_data[ccc_pkg::MA_W-1:0];
				ccc_pkg::CFG_TEST_MODE:    test_mode_q <= cfg_data[0];
				ccc_pkg::CFG_IDLE_TIMEOUT: timeout_q   <= cfg_data[ccc_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	// latch the sample item on acceptance
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vcode_q <= voltage_code;
			icode_q <= current_code;
			now_q   <= now_ms;
		end
	end

	// scaling: multiply, then shift, offset and saturate
	always_ff @(posedge clk) begin
		vprod_s1 <= VP_W'(vcode_q) * VP_W'(span_q);
		iprod_s1 <= IP_W'(icode_q) * IP_W'(rated_q);
	end

	assign volt_sum = {1'b0, min_volt_q}
		+ (ccc_pkg::MV_W+1)'(vprod_s1[VP_W-1:CODE_BITS]);

	always_ff @(posedge clk) begin
		volt_s2 <= (volt_sum > ccc_pkg::VOLT_MAX) ? ccc_pkg::VOLT_MAX[ccc_pkg::MV_W-1:0]
			: volt_sum[ccc_pkg::MV_W-1:0];
		// code*rated >> CODE_BITS stays below rated, so no saturation is needed
		cur_s2  <= iprod_s1[IP_W-1:CODE_BITS];
	end

	// divider operands
	assign div_dividend = charge_q;
	assign div_divisor  = rated_q;

	assign idle_end   = {1'b0, idle_start_q} + {1'b0, timeout_q};
	assign volt_limit = {1'b0, target_q} + ccc_pkg::OVERSHOOT_MV;

	// next charge sequence state for the current sample
	always_comb begin
		phase_d      = phase_q;
		led_d        = led_q;
		idle_start_d = idle_start_q;
		kick_cnt_d   = kick_cnt_q;
		out_on_d     = out_on_q;
		fans_d       = fans_q;
		disp_d       = disp_q;
		kick_d       = 1'b0;
		potw_d       = 1'b0;
		if (phase_q != ccc_pkg::PH_FAULT) begin
			case (phase_q)
				ccc_pkg::PH_SOFT: begin
					phase_d  = ccc_pkg::PH_CC;
					out_on_d = 1'b1;
					led_d    = ccc_pkg::LED_RED;
					potw_d   = 1'b1;
				end
				ccc_pkg::PH_CC: begin
					if (volt_s2 >= target_q) begin
						phase_d = ccc_pkg::PH_CV;
						led_d   = ccc_pkg::LED_YELLOW;
					end
				end
				ccc_pkg::PH_CV: begin
					if (cur_s2 <= cutoff_q && test_mode_q) begin
						phase_d      = ccc_pkg::PH_IDLE;
						idle_start_d = now_q;
						led_d        = ccc_pkg::LED_GREEN;
						out_on_d     = 1'b0;
						// early idle with overshoot: no battery connected
						if (now_q < ccc_pkg::EARLY_MS && {1'b0, volt_s2} > volt_limit) begin
							phase_d = ccc_pkg::PH_FAULT;
							fans_d  = 1'b0;
							led_d   = ccc_pkg::LED_RED;
						end
					end
					// current bands; band edges leave the LED as it is
					if (!test_mode_q) begin
						if (cur_s2 < ccc_pkg::BAND_LOW_MA) begin
							led_d = ccc_pkg::LED_GREEN;
						end else if (cur_s2 > ccc_pkg::BAND_LOW_MA
							&& cur_s2 < ccc_pkg::BAND_HIGH_MA) begin
							led_d = ccc_pkg::LED_YELLOW;
						end else if (cur_s2 > ccc_pkg::BAND_HIGH_MA) begin
							led_d = ccc_pkg::LED_RED;
						end
					end
				end
				ccc_pkg::PH_IDLE: begin
					if (idle_end < {1'b0, now_q}) begin
						phase_d = ccc_pkg::PH_DARK;
						disp_d  = 1'b0;
						fans_d  = 1'b0;
					end
				end
				default: ;
			endcase
			// watchdog: every 11th sample kicks
			if (phase_d != ccc_pkg::PH_FAULT) begin
				if (kick_cnt_q >= ccc_pkg::KICK_LIMIT) begin
					kick_d     = 1'b1;
					kick_cnt_d = '0;
				end else begin
					kick_cnt_d = kick_cnt_q + 1'b1;
				end
			end
		end
	end

	// charge sequence state, updated on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ccc_pkg::PH_SOFT;
			led_q        <= ccc_pkg::LED_OFF;
			idle_start_q <= '0;
			kick_cnt_q   <= '0;
			out_on_q     <= 1'b0;
			fans_q       <= 1'b1;
			disp_q       <= 1'b1;
		end else if (cmd.commit) begin
			phase_q      <= phase_d;
			led_q        <= led_d;
			idle_start_q <= idle_start_d;
			kick_cnt_q   <= kick_cnt_d;
			out_on_q     <= out_on_d;
			fans_q       <= fans_d;
			disp_q       <= disp_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			voltage_mv_q    <= volt_s2;
			current_ma_q    <= cur_s2;
			charge_state_q  <= phase_d;
			led_color_q     <= led_d;
			output_enable_q <= out_on_d;
			fans_on_q       <= fans_d;
			display_on_q    <= disp_d;
			watchdog_kick_q <= kick_d;
			pot_write_q     <= potw_d;
			pot_code_q      <= div_quotient;
		end
	end

	assign out_busy      = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign voltage_mv    = voltage_mv_q;
	assign current_ma    = current_ma_q;
	assign charge_state  = charge_state_q;
	assign led_color     = led_color_q;
	assign output_enable = output_enable_q;
	assign fans_on       = fans_on_q;
	assign display_on    = display_on_q;
	assign watchdog_kick = watchdog_kick_q;
	assign pot_write     = pot_write_q;
	assign pot_code      = pot_code_q;

endmodule
`default_nettype wire

// ===== rtl/cc_cv_charge_controller_unit.sv =====
// A sample item is latched on acceptance and scaled while the 8-step
// pot-code divider runs; its result is committed once the divider is done.
// One item at a time. A finished result waits in the output register.
// Reset (arst_n low, asynchronous): config registers to defaults, soft start,
// LED off, output off, fans and display on, watchdog counter cleared.
// Top level: CC/CV charge controller, sequencer plus datapath plus pot divider.
`default_nettype none
module cc_cv_charge_controller_unit #(
	parameter int CODE_BITS = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [ccc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ccc_pkg::CFG_W-1:0]      cfg_data,
	// sample input channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [CODE_BITS-1:0]           voltage_code,
	input  wire logic [CODE_BITS-1:0]           current_code,
	input  wire logic [ccc_pkg::MS_W-1:0]       now_ms,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [ccc_pkg::MV_W-1:0]            voltage_mv,
	output logic [ccc_pkg::MA_W-1:0]            current_ma,
	output logic [2:0]                          charge_state,
	output logic [1:0]                          led_color,
	output logic                                output_enable,
	output logic                                fans_on,
	output logic                                display_on,
	output logic                                watchdog_kick,
	output logic                                pot_write,
	output logic [ccc_pkg::POT_W-1:0]           pot_code
);

	ccc_pkg::cmd_t              cmd;
	ccc_pkg::sts_t              sts;
	logic                       div_done;
	logic                       out_busy;
	logic [ccc_pkg::MA_W-1:0]   div_dividend, div_divisor;
	logic [ccc_pkg::POT_W-1:0]  div_quotient;

	assign sts.div_done = div_done;
	assign sts.out_busy = out_busy;

	ccc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ccc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	ccc_datapath #(
		.CODE_BITS (CODE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.voltage_code  (voltage_code),
		.current_code  (current_code),
		.now_ms        (now_ms),
		.cmd           (cmd),
		.out_busy      (out_busy),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_quotient  (div_quotient),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.voltage_mv    (voltage_mv),
		.current_ma    (current_ma),
		.charge_state  (charge_state),
		.led_color     (led_color),
		.output_enable (output_enable),
		.fans_on       (fans_on),
		.display_on    (display_on),
		.watchdog_kick (watchdog_kick),
		.pot_write     (pot_write),
		.pot_code      (pot_code)
	);

endmodule
`default_nettype wire
